FILE: design/stvr_pkg.sv
// Shared types and constants for the stepper velocity ramp.
// Used by stvr_regs, stvr_ctrl, stvr_dp and stepper_velocity_ramp.
`default_nettype none

package stvr_pkg;

    localparam int VEL_W   = 16;
    localparam int DT_W    = 16;
    localparam int RPM_W   = 14;
    localparam int SRPM_W  = 15;
    localparam int SPR_W   = 11;
    localparam int MS_W    = 9;
    localparam int FREQ_W  = 18;
    localparam int ACC_W   = 16;

    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 29;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [VEL_W-1:0]   DEADZONE_LSB = 16'd33;
    localparam logic [MUL_B_W-1:0] RECIP_15     = 29'h1111_1112;

    localparam logic [2:0] REG_ACCEL   = 3'd0;
    localparam logic [2:0] REG_RPM_LO  = 3'd1;
    localparam logic [2:0] REG_RPM_HI  = 3'd2;
    localparam logic [2:0] REG_SPR     = 3'd3;
    localparam logic [2:0] REG_MICRO   = 3'd4;
    localparam logic [2:0] REG_INVERT  = 3'd5;
    localparam logic [2:0] REG_FREQ_LO = 3'd6;
    localparam logic [2:0] REG_FREQ_HI = 3'd7;

    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_LIM  = 3'd1;
    localparam logic [2:0] MUL_SPAN = 3'd2;
    localparam logic [2:0] MUL_SPR  = 3'd3;
    localparam logic [2:0] MUL_MS   = 3'd4;
    localparam logic [2:0] MUL_REC  = 3'd5;

    typedef struct packed {
        logic [ACC_W-1:0]  accel_rate;
        logic [RPM_W-1:0]  rpm_low;
        logic [RPM_W-1:0]  rpm_high;
        logic [SPR_W-1:0]  rev_steps;
        logic [MS_W-1:0]   microstep_factor;
        logic              invert_direction;
        logic [FREQ_W-1:0] freq_low;
        logic [FREQ_W-1:0] freq_high;
    } t_cfg;

    typedef struct packed {
        logic       load_in;
        logic [2:0] mul_sel;
        logic       ramp;
        logic       rpm;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic dead;
    } t_sts;

endpackage

`default_nettype wire

FILE: design/stvr_regs.sv
// Configuration register file behind the APB-style port.
// Depends on stvr_pkg.
`default_nettype none

module stvr_regs
    import stvr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_rate       <= 16'd1024;
            r_cfg.rpm_low          <= 14'd160;
            r_cfg.rpm_high         <= 14'd400;
            r_cfg.rev_steps        <= 11'd200;
            r_cfg.microstep_factor <= 9'd16;
            r_cfg.invert_direction <= 1'b0;
            r_cfg.freq_low         <= 18'd100;
            r_cfg.freq_high        <= 18'd20000;
        end else if (wr_en) begin
            case (idx)
                REG_ACCEL:   r_cfg.accel_rate       <= pwdata[ACC_W-1:0];
                REG_RPM_LO:  r_cfg.rpm_low          <= pwdata[RPM_W-1:0];
                REG_RPM_HI:  r_cfg.rpm_high         <= pwdata[RPM_W-1:0];
                REG_SPR:     r_cfg.rev_steps        <= pwdata[SPR_W-1:0];
                REG_MICRO:   r_cfg.microstep_factor <= pwdata[MS_W-1:0];
                REG_INVERT:  r_cfg.invert_direction <= pwdata[0];
                REG_FREQ_LO: r_cfg.freq_low         <= pwdata[FREQ_W-1:0];
                REG_FREQ_HI: r_cfg.freq_high        <= pwdata[FREQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ACCEL:   prdata = {{(DATA_W-ACC_W){1'b0}}, r_cfg.accel_rate};
            REG_RPM_LO:  prdata = {{(DATA_W-RPM_W){1'b0}}, r_cfg.rpm_low};
            REG_RPM_HI:  prdata = {{(DATA_W-RPM_W){1'b0}}, r_cfg.rpm_high};
            REG_SPR:     prdata = {{(DATA_W-SPR_W){1'b0}}, r_cfg.rev_steps};
            REG_MICRO:   prdata = {{(DATA_W-MS_W){1'b0}}, r_cfg.microstep_factor};
            REG_INVERT:  prdata = {{(DATA_W-1){1'b0}}, r_cfg.invert_direction};
            REG_FREQ_LO: prdata = {{(DATA_W-FREQ_W){1'b0}}, r_cfg.freq_low};
            REG_FREQ_HI: prdata = {{(DATA_W-FREQ_W){1'b0}}, r_cfg.freq_high};
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/stvr_ctrl.sv
// Sequencer for the velocity ramp: handshakes and datapath commands.
// Depends on stvr_pkg.
`default_nettype none

module stvr_ctrl
    import stvr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LIM  = 4'd1;
    localparam logic [3:0] S_RAMP = 4'd2;
    localparam logic [3:0] S_SPAN = 4'd3;
    localparam logic [3:0] S_RPM  = 4'd4;
    localparam logic [3:0] S_MSPR = 4'd5;
    localparam logic [3:0] S_MMS  = 4'd6;
    localparam logic [3:0] S_MREC = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_LIM;
                end
            end
            S_LIM: begin
                o_cmd.mul_sel = MUL_LIM;
                n_state       = S_RAMP;
            end
            S_RAMP: begin
                o_cmd.ramp = 1'b1;
                n_state    = S_SPAN;
            end
            S_SPAN: begin
                o_cmd.mul_sel = MUL_SPAN;
                n_state       = i_sts.dead ? S_OUT : S_RPM;
            end
            S_RPM: begin
                o_cmd.rpm = 1'b1;
                n_state   = S_MSPR;
            end
            S_MSPR: begin
                o_cmd.mul_sel = MUL_SPR;
                n_state       = S_MMS;
            end
            S_MMS: begin
                o_cmd.mul_sel = MUL_MS;
                n_state       = S_MREC;
            end
            S_MREC: begin
                o_cmd.mul_sel = MUL_REC;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: design/stvr_dp.sv
// Datapath: ramp state, shared multiplier, rpm and frequency math, result word.
// Depends on stvr_pkg.
`default_nettype none

module stvr_dp
    import stvr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cfg                     i_cfg,
    input  wire t_cmd                     i_cmd,
    output t_sts                          o_sts,
    input  wire logic signed [VEL_W-1:0]  i_target_velocity,
    input  wire logic        [DT_W-1:0]   i_elapsed_us,
    output logic                          o_running,
    output logic                          o_direction,
    output logic             [FREQ_W-1:0] o_step_freq_hz,
    output logic signed      [SRPM_W-1:0] o_signed_rpm,
    output logic signed      [VEL_W-1:0]  o_current_velocity
);

    logic signed [VEL_W-1:0]  r_target;
    logic        [DT_W-1:0]   r_dt;
    logic signed [VEL_W-1:0]  r_vel, n_vel;
    logic                     r_last_dir;
    logic        [RPM_W-1:0]  r_rpm, n_rpm;
    logic        [PROD_W-1:0] r_prod;

    logic        [MUL_A_W-1:0] mul_a;
    logic        [MUL_B_W-1:0] mul_b;

    logic        [VEL_W-1:0]  mag;
    logic        [VEL_W-1:0]  limit;
    logic signed [VEL_W:0]    delta, lim_pos, lim_neg, delta_c;
    logic signed [RPM_W:0]    span;
    logic        [RPM_W-1:0]  span_abs;
    logic        [RPM_W-1:0]  part;
    logic        [24:0]       freq_raw;
    logic        [24:0]       freq_lo_sat;
    logic        [FREQ_W-1:0] freq_sat;
    logic        [SRPM_W-1:0] rpm_ext;

    assign mag      = r_vel[VEL_W-1] ? (~r_vel + 1'b1) : r_vel;
    assign o_sts.dead = (mag <= DEADZONE_LSB);

    assign span     = $signed({1'b0, i_cfg.rpm_high}) - $signed({1'b0, i_cfg.rpm_low});
    assign span_abs = span[RPM_W] ? RPM_W'(-span) : span[RPM_W-1:0];

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_LIM: begin
                mul_a = MUL_A_W'(i_cfg.accel_rate);
                mul_b = MUL_B_W'(r_dt);
            end
            MUL_SPAN: begin
                mul_a = MUL_A_W'(span_abs);
                mul_b = MUL_B_W'(mag);
            end
            MUL_SPR: begin
                mul_a = MUL_A_W'(r_rpm);
                mul_b = MUL_B_W'(i_cfg.rev_steps);
            end
            MUL_MS: begin
                mul_a = MUL_A_W'(r_prod[24:0]);
                mul_b = MUL_B_W'(i_cfg.microstep_factor);
            end
            MUL_REC: begin
                mul_a = r_prod[33:6];
                mul_b = RECIP_15;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // slew limit
    always_comb begin
        limit   = r_prod[31:16];
        delta   = $signed({r_target[VEL_W-1], r_target}) - $signed({r_vel[VEL_W-1], r_vel});
        lim_pos = $signed({1'b0, limit});
        lim_neg = -lim_pos;
        if (delta > lim_pos) begin
            delta_c = lim_pos;
        end else if (delta < lim_neg) begin
            delta_c = lim_neg;
        end else begin
            delta_c = delta;
        end
        if (r_dt == '0 || i_cfg.accel_rate == '0) begin
            n_vel = r_target;
        end else begin
            n_vel = VEL_W'($signed({r_vel[VEL_W-1], r_vel}) + delta_c);
        end
    end

    assign part  = r_prod[28:15];
    assign n_rpm = span[RPM_W] ? (i_cfg.rpm_low - part) : (i_cfg.rpm_low + part);

    always_comb begin
        freq_raw    = r_prod[56:32];
        freq_lo_sat = (freq_raw < 25'(i_cfg.freq_low)) ? 25'(i_cfg.freq_low) : freq_raw;
        freq_sat    = (freq_lo_sat > 25'(i_cfg.freq_high)) ? i_cfg.freq_high
                                                           : freq_lo_sat[FREQ_W-1:0];
        rpm_ext     = {1'b0, r_rpm};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel      <= '0;
            r_last_dir <= 1'b1;
        end else begin
            if (i_cmd.ramp) begin
                r_vel <= n_vel;
            end
            if (i_cmd.rpm) begin
                r_last_dir <= ~r_vel[VEL_W-1] ^ i_cfg.invert_direction;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_target <= i_target_velocity;
            r_dt     <= i_elapsed_us;
        end
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.rpm) begin
            r_rpm <= n_rpm;
        end
        if (i_cmd.out_load) begin
            o_running          <= ~o_sts.dead;
            o_direction        <= r_last_dir;
            o_current_velocity <= r_vel;
            if (o_sts.dead) begin
                o_step_freq_hz <= '0;
                o_signed_rpm   <= '0;
            end else begin
                o_step_freq_hz <= freq_sat;
                o_signed_rpm   <= r_last_dir ? rpm_ext : (~rpm_ext + 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/stepper_velocity_ramp.sv
// Stepper velocity ramp top level: register file, sequencer and datapath.
// Depends on stvr_pkg, stvr_regs, stvr_ctrl and stvr_dp.
//
// Each accepted tick word slews the ramped velocity toward its target and
// returns one result word: running flag, direction, step frequency, signed
// rpm and the new velocity. A tick steps through S_LIM, S_RAMP, S_SPAN,
// S_RPM, S_MSPR, S_MMS, S_MREC and S_OUT; in the deadzone it goes from S_SPAN
// straight to S_OUT. The result loads in S_OUT and the next tick is taken
// back in S_IDLE. One shared multiplier is used in turn for the slew limit,
// the rpm map, the two step-rate products and the divide by 960. A finished
// result waits in the output register while the next tick is accepted and
// processed; if it is still stalled then, the next result load waits for it.
`default_nettype none

module stepper_velocity_ramp
    import stvr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic signed [VEL_W-1:0]  i_target_velocity,
    input  wire logic        [DT_W-1:0]   i_elapsed_us,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic                          o_running,
    output logic                          o_direction,
    output logic             [FREQ_W-1:0] o_step_freq_hz,
    output logic signed      [SRPM_W-1:0] o_signed_rpm,
    output logic signed      [VEL_W-1:0]  o_current_velocity,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic        [ADDR_W-1:0] paddr,
    input  wire logic        [DATA_W-1:0] pwdata,
    output logic             [DATA_W-1:0] prdata,
    output logic                          pready
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    stvr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    stvr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    stvr_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_target_velocity  (i_target_velocity),
        .i_elapsed_us       (i_elapsed_us),
        .o_running          (o_running),
        .o_direction        (o_direction),
        .o_step_freq_hz     (o_step_freq_hz),
        .o_signed_rpm       (o_signed_rpm),
        .o_current_velocity (o_current_velocity)
    );

endmodule

`default_nettype wire
